// ===== hdl/bcpe_pkg.sv =====
// bcpe_pkg: shared constants, codes and structs for the bezier point evaluator
// no dependencies; compiled first

package bcpe_pkg;

   // control point storage
   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);

   // fixed field widths
   localparam int INDEX_W = 6;
   localparam int COORD_W = 16;
   localparam int CNT_W   = 7;
   localparam int OUT_W   = 24;

   // fixed point formats
   localparam int T_FRAC_BITS = 16;
   localparam int T_W         = T_FRAC_BITS + 1;
   localparam int POS_FRAC    = 16;
   localparam int SCR_W       = COORD_W + POS_FRAC;
   localparam int OUT_SHIFT   = 8;
   localparam int DIFF_W      = SCR_W + 1;
   localparam int PROD_W      = T_W + 1 + DIFF_W;

   localparam logic [T_W-1:0]   T_ONE           = T_W'(1) << T_FRAC_BITS;
   localparam logic [CNT_W-1:0] POINT_COUNT_RST = CNT_W'(2);

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef struct packed {
      logic                    vld;
      logic                    sel_y;
      logic [IDX_W-1:0]        addr;
      logic signed [SCR_W-1:0] a;
      logic signed [SCR_W-1:0] b;
   } lerp_req_type;

   typedef struct packed {
      logic                    vld;
      logic                    sel_y;
      logic [IDX_W-1:0]        addr;
      logic signed [SCR_W-1:0] value;
   } lerp_rsp_type;

   typedef struct packed {
      logic                    vld;
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
   } eval_res_type;

endpackage

// ===== hdl/bcpe_if.sv =====
// bcpe_req_if and bcpe_rsp_if: valid/ready channels of the bezier point evaluator
// depends on bcpe_pkg

interface bcpe_req_if;
   import bcpe_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [INDEX_W-1:0]        index;
   logic signed [COORD_W-1:0] x_in;
   logic signed [COORD_W-1:0] y_in;
   logic [T_W-1:0]            t_param;

   modport source (output valid, op, index, x_in, y_in, t_param, input ready);
   modport sink   (input valid, op, index, x_in, y_in, t_param, output ready);
endinterface

interface bcpe_rsp_if;
   import bcpe_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] x_out;
   logic signed [OUT_W-1:0] y_out;

   modport source (output valid, x_out, y_out, input ready);
   modport sink   (input valid, x_out, y_out, output ready);
endinterface

// ===== hdl/bezier_curve_point_eval.sv =====
// bezier_curve_point_eval: top level of the de casteljau bezier point evaluator
// depends on bcpe_pkg, bcpe_if, bcpe_lerp_unit and bcpe_ctrl
// a load transaction writes one control point; an evaluate transaction copies the points
// into scratch, then runs each round on one shared interpolator fed x then y each step,
// and waits for the pipeline to drain at the end of the copy and of every round
// one transaction at a time; a finished result waits in the output register
// reset: synchronous, clears control state and sets point_count to 2; no clearing pass

module bezier_curve_point_eval (
   input  logic                         clock,
   input  logic                         reset,
   bcpe_req_if.sink                     req_chan,
   bcpe_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [bcpe_pkg::CNT_W-1:0]   csr_wr_data
);
   import bcpe_pkg::*;

   logic [CNT_W-1:0]        point_count_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                    res_ready;
   eval_res_type            res;
   lerp_req_type            lerp_req;
   lerp_rsp_type            lerp_rsp;
   logic                    lerp_busy;
   logic [T_W-1:0]          t_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= POINT_COUNT_RST;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.vld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.vld) begin
         rsp_x_ff <= res.x;
         rsp_y_ff <= res.y;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.x_out = rsp_x_ff;
   assign rsp_chan.y_out = rsp_y_ff;

   bcpe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .point_count (point_count_ff),
      .res_ready   (res_ready),
      .res         (res),
      .lerp_req    (lerp_req),
      .lerp_rsp    (lerp_rsp),
      .lerp_busy   (lerp_busy),
      .t_val       (t_val)
   );

   bcpe_lerp_unit u_lerp (
      .clock (clock),
      .reset (reset),
      .req   (lerp_req),
      .t_val (t_val),
      .rsp   (lerp_rsp),
      .busy  (lerp_busy)
   );

endmodule

// ===== hdl/bcpe_lerp_unit.sv =====
// bcpe_lerp_unit: shared three stage interpolator a + ((t*(b-a)) >>> frac)
// depends on bcpe_pkg

module bcpe_lerp_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  bcpe_pkg::lerp_req_type         req,
   input  logic [bcpe_pkg::T_W-1:0]       t_val,
   output bcpe_pkg::lerp_rsp_type         rsp,
   output logic                           busy
);
   import bcpe_pkg::*;

   logic                     s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic                     s1_sel_ff, s2_sel_ff, s3_sel_ff;
   logic [IDX_W-1:0]         s1_addr_ff, s2_addr_ff, s3_addr_ff;
   logic signed [SCR_W-1:0]  s1_a_ff, s2_a_ff;
   logic signed [DIFF_W-1:0] s1_diff_ff;
   logic signed [DIFF_W-1:0] diff_in;
   logic signed [PROD_W-1:0] prod;
   logic signed [SCR_W-1:0]  s2_delta_ff;
   logic signed [SCR_W-1:0]  s3_value_ff;

   assign diff_in = DIFF_W'(req.b) - DIFF_W'(req.a);
   assign prod    = $signed({1'b0, t_val}) * s1_diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req.vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_sel_ff   <= req.sel_y;
      s1_addr_ff  <= req.addr;
      s1_a_ff     <= req.a;
      s1_diff_ff  <= diff_in;
      s2_sel_ff   <= s1_sel_ff;
      s2_addr_ff  <= s1_addr_ff;
      s2_a_ff     <= s1_a_ff;
      // floor shift of the product, the sum stays inside the hull
      s2_delta_ff <= prod[T_FRAC_BITS +: SCR_W];
      s3_sel_ff   <= s2_sel_ff;
      s3_addr_ff  <= s2_addr_ff;
      s3_value_ff <= s2_a_ff + s2_delta_ff;
   end

   assign rsp.vld   = s3_vld_ff;
   assign rsp.sel_y = s3_sel_ff;
   assign rsp.addr  = s3_addr_ff;
   assign rsp.value = s3_value_ff;
   assign busy      = s1_vld_ff | s2_vld_ff | s3_vld_ff;

endmodule

// ===== hdl/bcpe_ctrl.sv =====
// bcpe_ctrl: sequencer, control point store and scratch memories of the evaluator
// depends on bcpe_pkg and bcpe_if

module bcpe_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   bcpe_req_if.sink                     req_chan,
   input  logic [bcpe_pkg::CNT_W-1:0]   point_count,
   input  logic                         res_ready,
   output bcpe_pkg::eval_res_type       res,
   output bcpe_pkg::lerp_req_type       lerp_req,
   input  bcpe_pkg::lerp_rsp_type       lerp_rsp,
   input  logic                         lerp_busy,
   output logic [bcpe_pkg::T_W-1:0]     t_val
);
   import bcpe_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_COPY   = 6'b000010,
      ST_DRAIN  = 6'b000100,
      ST_ISSUE  = 6'b001000,
      ST_READ0  = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        i_ff, i_in;
   logic                    phase_ff, phase_in;
   logic [IDX_W-1:0]        len_ff, len_in;
   logic [T_W-1:0]          t_ff, t_in;

   logic                    copy_rd;
   logic                    copy_wr_vld_ff;
   logic [IDX_W-1:0]        copy_addr_ff;
   logic signed [COORD_W-1:0] pt_x_rd_ff, pt_y_rd_ff;

   logic                    issue;
   logic                    rd_vld_ff, rd_sel_ff;
   logic [IDX_W-1:0]        rd_addr_ff;
   logic [IDX_W-1:0]        addr_a, addr_b;
   logic signed [SCR_W-1:0] rd_ax_ff, rd_bx_ff, rd_ay_ff, rd_by_ff;

   logic                    load_wr;
   logic                    pipe_busy;

   logic signed [COORD_W-1:0] pt_x_mem [MAX_POINTS];
   logic signed [COORD_W-1:0] pt_y_mem [MAX_POINTS];
   logic signed [SCR_W-1:0]   scr_x_mem [MAX_POINTS];
   logic signed [SCR_W-1:0]   scr_y_mem [MAX_POINTS];

   assign pipe_busy      = copy_wr_vld_ff | rd_vld_ff | lerp_busy;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign t_val          = t_ff;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      phase_in = phase_ff;
      len_in   = len_ff;
      t_in     = t_ff;
      addr_a   = '0;
      addr_b   = '0;
      issue    = 1'b0;
      copy_rd  = 1'b0;
      load_wr  = 1'b0;
      res.vld  = 1'b0;
      res.x    = rd_ax_ff[OUT_SHIFT +: OUT_W];
      res.y    = rd_ay_ff[OUT_SHIFT +: OUT_W];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               unique case (req_chan.op)
                  OP_LOAD: begin
                     load_wr = 1'b1;
                  end
                  OP_EVAL: begin
                     t_in = (req_chan.t_param > T_ONE) ? T_ONE : req_chan.t_param;
                     // rounds to run: point count clamped to 1..MAX_POINTS, minus one
                     if (point_count == '0) begin
                        len_in = '0;
                     end else if (point_count > CNT_W'(MAX_POINTS)) begin
                        len_in = IDX_W'(MAX_POINTS - 1);
                     end else begin
                        len_in = IDX_W'(point_count - 1'b1);
                     end
                     i_in     = '0;
                     state_in = ST_COPY;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_COPY: begin
            copy_rd = 1'b1;
            if (i_ff == len_ff) begin
               state_in = ST_DRAIN;
            end else begin
               i_in = IDX_W'(i_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            // next round only once every write of this one has landed
            if (!pipe_busy) begin
               i_in     = '0;
               phase_in = 1'b0;
               if (len_ff == '0) begin
                  state_in = ST_READ0;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            issue    = 1'b1;
            addr_a   = i_ff;
            addr_b   = IDX_W'(i_ff + 1'b1);
            phase_in = ~phase_ff;
            if (phase_ff) begin
               if (i_ff == IDX_W'(len_ff - 1'b1)) begin
                  len_in   = IDX_W'(len_ff - 1'b1);
                  state_in = ST_DRAIN;
               end else begin
                  i_in = IDX_W'(i_ff + 1'b1);
               end
            end
         end
         ST_READ0: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            res.vld = res_ready;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         copy_wr_vld_ff <= 1'b0;
         rd_vld_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         copy_wr_vld_ff <= copy_rd;
         rd_vld_ff      <= issue;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      phase_ff     <= phase_in;
      len_ff       <= len_in;
      t_ff         <= t_in;
      copy_addr_ff <= i_ff;
      rd_sel_ff    <= phase_ff;
      rd_addr_ff   <= i_ff;
   end

   // control point store
   always_ff @(posedge clock) begin
      if (load_wr && (32'(req_chan.index) < MAX_POINTS)) begin
         pt_x_mem[IDX_W'(req_chan.index)] <= req_chan.x_in;
         pt_y_mem[IDX_W'(req_chan.index)] <= req_chan.y_in;
      end
      pt_x_rd_ff <= pt_x_mem[i_ff];
      pt_y_rd_ff <= pt_y_mem[i_ff];
   end

   // scratch, one write port and two read ports per coordinate
   always_ff @(posedge clock) begin
      if (copy_wr_vld_ff) begin
         scr_x_mem[copy_addr_ff] <= {pt_x_rd_ff, POS_FRAC'(0)};
         scr_y_mem[copy_addr_ff] <= {pt_y_rd_ff, POS_FRAC'(0)};
      end else if (lerp_rsp.vld) begin
         if (lerp_rsp.sel_y) begin
            scr_y_mem[lerp_rsp.addr] <= lerp_rsp.value;
         end else begin
            scr_x_mem[lerp_rsp.addr] <= lerp_rsp.value;
         end
      end
      rd_ax_ff <= scr_x_mem[addr_a];
      rd_bx_ff <= scr_x_mem[addr_b];
      rd_ay_ff <= scr_y_mem[addr_a];
      rd_by_ff <= scr_y_mem[addr_b];
   end

   assign lerp_req.vld   = rd_vld_ff;
   assign lerp_req.sel_y = rd_sel_ff;
   assign lerp_req.addr  = rd_addr_ff;
   assign lerp_req.a     = rd_sel_ff ? rd_ay_ff : rd_ax_ff;
   assign lerp_req.b     = rd_sel_ff ? rd_by_ff : rd_bx_ff;

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(copy_wr_vld_ff && lerp_rsp.vld))
      else $error("copy and interpolation write scratch in the same cycle");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_busy)
      else $error("pipeline still busy while idle");

   a_issue_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (len_ff != '0))
      else $error("round issued with no steps left");

   a_result_done: assert property (@(posedge clock) disable iff (reset)
      res.vld |=> (state_ff == ST_IDLE))
      else $error("result handed out without returning to idle");

endmodule

// ===== tb/sv/tb_bezier_curve_point_eval.sv =====
// tb_bezier_curve_point_eval: self-checking testbench for the de casteljau bezier point evaluator
// loads control points, sweeps point_count and t, and checks every curve point against a predictor
// depends on bcpe_pkg, bcpe_if and the bezier_curve_point_eval rtl

module tb_bezier_curve_point_eval;
   timeunit 1ns;
   timeprecision 1ps;
   import bcpe_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 50;

   typedef struct {
      logic                      op;
      logic [INDEX_W-1:0]        index;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [T_W-1:0]            t;
   } bez_item_type;

   typedef struct {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
   } curve_point_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             csr_wr_en   = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   bcpe_req_if req_chan ();
   bcpe_rsp_if rsp_chan ();

   bezier_curve_point_eval dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // predictor state
   logic signed [COORD_W-1:0] ctrl_x [MAX_POINTS];
   logic signed [COORD_W-1:0] ctrl_y [MAX_POINTS];
   logic [CNT_W-1:0]          point_count_cfg = POINT_COUNT_RST;
   curve_point_type           expected_points [$];

   // stimulus state
   bez_item_type pending_items [$];
   bit           slot_loaded [MAX_POINTS];
   bez_item_type next_item;
   int           burst_left = 0;
   int           gap_left   = 0;
   int           phase_counts [13] = '{3, 1, 5, 8, 2, 16, 64, 0, 127, 6, 4, 100, 7};

   logic [15:0] stall_pattern = '1;
   int          stall_pos     = 0;
   int          mismatches    = 0;
   int          cycle_count   = 0;

   function automatic int active_points(input logic [CNT_W-1:0] count);
      if (count == 0) return 1;
      if (count > MAX_POINTS) return MAX_POINTS;
      return int'(count);
   endfunction

   task automatic eval_curve_point(input logic [T_W-1:0] t_raw);
      longint          sx [MAX_POINTS];
      longint          sy [MAX_POINTS];
      longint          t;
      int              n;
      curve_point_type pt;
      t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
      n = active_points(point_count_cfg);
      for (int i = 0; i < n; i++) begin
         sx[i] = longint'(ctrl_x[i]) * (longint'(1) << POS_FRAC);
         sy[i] = longint'(ctrl_y[i]) * (longint'(1) << POS_FRAC);
      end
      for (int r = 0; r < n - 1; r++) begin
         for (int i = 0; i < n - 1 - r; i++) begin
            sx[i] = sx[i] + ((t * (sx[i+1] - sx[i])) >>> T_FRAC_BITS);
            sy[i] = sy[i] + ((t * (sy[i+1] - sy[i])) >>> T_FRAC_BITS);
         end
      end
      pt.x = OUT_W'(sx[0] >>> OUT_SHIFT);
      pt.y = OUT_W'(sy[0] >>> OUT_SHIFT);
      expected_points = {expected_points, pt};
   endtask

   // driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.op == OP_LOAD) begin
               ctrl_x[req_chan.index] = req_chan.x_in;
               ctrl_y[req_chan.index] = req_chan.y_in;
            end else begin
               eval_curve_point(req_chan.t_param);
            end
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               next_item = pending_items.pop_front();
               req_chan.valid   <= 1'b1;
               req_chan.op      <= next_item.op;
               req_chan.index   <= next_item.index;
               req_chan.x_in    <= next_item.x;
               req_chan.y_in    <= next_item.y;
               req_chan.t_param <= next_item.t;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each curve point, ready follows a reshuffled stall pattern
   always @(posedge clock) begin
      curve_point_type exp_pt;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected curve point x_out=%0d y_out=%0d",
                      rsp_chan.x_out, rsp_chan.y_out);
               mismatches++;
            end else begin
               exp_pt = expected_points.pop_front();
               if (rsp_chan.x_out !== exp_pt.x) begin
                  $error("x_out: expected %0d, got %0d", exp_pt.x, rsp_chan.x_out);
                  mismatches++;
               end
               if (rsp_chan.y_out !== exp_pt.y) begin
                  $error("y_out: expected %0d, got %0d", exp_pt.y, rsp_chan.y_out);
                  mismatches++;
               end
            end
         end
         if (stall_pos == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = '1;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'($urandom | $urandom);
               default: stall_pattern = 16'($urandom & $urandom);
            endcase
         end
         rsp_chan.ready <= stall_pattern[stall_pos];
         stall_pos = (stall_pos + 1) % 16;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return COORD_W'($urandom_range(0, 200) - 100);
         1: return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [T_W-1:0] rand_t();
      case ($urandom_range(0, 4))
         0: return ($urandom_range(0, 1) == 1) ? T_ONE : '0;
         1: return T_W'($urandom_range(0, (1 << T_W) - 1));
         default: return T_W'($urandom_range(0, int'(T_ONE)));
      endcase
   endfunction

   task automatic push_load(input int slot, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
      bez_item_type it;
      it.op    = OP_LOAD;
      it.index = INDEX_W'(slot);
      it.x     = x;
      it.y     = y;
      it.t     = T_W'($urandom_range(0, (1 << T_W) - 1));
      slot_loaded[slot] = 1'b1;
      pending_items = {pending_items, it};
   endtask

   task automatic push_eval(input logic [T_W-1:0] t);
      bez_item_type it;
      it.op    = OP_EVAL;
      it.index = INDEX_W'($urandom);
      it.x     = COORD_W'($urandom);
      it.y     = COORD_W'($urandom);
      it.t     = t;
      pending_items = {pending_items, it};
   endtask

   task automatic wait_quiet();
      while (pending_items.size() != 0 || req_chan.valid || expected_points.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_point_count(input logic [CNT_W-1:0] value);
      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      point_count_cfg = value;
   endtask

   // evaluations only ever read slots that have been loaded
   task automatic fill_slots(input int n);
      for (int i = 0; i < n; i++)
         if (!slot_loaded[i]) push_load(i, rand_coord(), rand_coord());
   endtask

   initial begin
      int n;
      int items;
      req_chan.valid   = 1'b0;
      req_chan.op      = OP_LOAD;
      req_chan.index   = '0;
      req_chan.x_in    = '0;
      req_chan.y_in    = '0;
      req_chan.t_param = '0;
      rsp_chan.ready   = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: coordinate extremes, t at the ends, just inside and above one
      push_load(0, 16'sh8000, 16'sh7FFF);
      push_load(1, 16'sh7FFF, 16'sh8000);
      push_eval('0);
      push_eval(T_ONE);
      push_eval(T_W'(32768));
      push_eval(T_W'(1));
      push_eval(T_W'(T_ONE - 1));
      push_eval(T_W'(T_ONE + 1));
      push_eval('1);
      push_load(63, 16'sh7FFF, 16'sh7FFF);
      push_load(2, 16'sh0000, 16'sh0000);
      push_load(3, -16'sd1, 16'sd1);
      // single point, and zero count which acts as one point
      write_point_count(CNT_W'(1));
      push_eval(T_W'(12345));
      write_point_count('0);
      push_eval(T_ONE);
      write_point_count(CNT_W'(4));
      push_eval(T_W'(16384));
      push_eval(T_ONE);
      push_eval('0);

      // random phases, large counts get few transactions since they are slow
      foreach (phase_counts[p]) begin
         write_point_count(CNT_W'(phase_counts[p]));
         n = active_points(CNT_W'(phase_counts[p]));
         fill_slots(n);
         items = (n >= 64) ? 6 : (n >= 16) ? 12 : 20;
         for (int k = 0; k < items; k++) begin
            if (items >= 20 && k == items / 2) wait_quiet();
            if ($urandom_range(0, 99) < 55)
               push_eval(rand_t());
            else
               push_load($urandom_range(0, MAX_POINTS - 1), rand_coord(), rand_coord());
         end
      end

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/bcpe_pkg.sv
hdl/bcpe_if.sv
hdl/bcpe_lerp_unit.sv
hdl/bcpe_ctrl.sv
hdl/bezier_curve_point_eval.sv
tb/sv/tb_bezier_curve_point_eval.sv
